// ===== design/grll_pkg.sv =====
// Package for the genotype read log-likelihood accumulator.
// Holds the fixed-point widths, symbol and register codes, the sequencer
// state type and small helper functions. Depends on nothing.
`timescale 1ns / 1ps

package grll_pkg;

  // Fixed-point format of the probabilities and of the log terms.
  localparam int FB     = 16;            // fraction bits
  localparam int CNT_W  = 16;            // read counter width
  localparam int PROB_W = FB + 1;        // Q1.FB probability, 1.0 included
  localparam int P_W    = FB + 2;        // p with FB+1 fraction bits, up to 1.0
  localparam int B_W    = FB + 2;        // q + m + q*m, up to 3.0
  localparam int T_W    = 2 * FB + 3;    // mixture t with 2FB+1 fraction bits
  localparam int E_W    = $clog2(T_W);   // leading-one position
  localparam int NSTEPS = $clog2(T_W);   // normalisation steps
  localparam int STEP_W = $clog2(NSTEPS);
  localparam int ITER_W = $clog2(FB);
  localparam int IP_W   = E_W + 1;       // signed integer part of log2
  localparam int L_W    = IP_W + FB;     // signed log2 value
  localparam int Y_W    = 31;            // Q1.30 mantissa
  localparam int MUL_W  = 32;            // shared multiplier operand width
  localparam int SUM_W  = 41;            // accumulated log-likelihood
  localparam int CFG_W  = PROB_W;        // widest configuration register
  localparam int CFG_IDX_W = 2;

  localparam logic [MUL_W-1:0]  LN2_Q32 = 32'hB172_17F8;
  localparam logic [PROB_W-1:0] ONE_F   = {1'b1, {FB{1'b0}}};
  localparam logic [P_W-1:0]    ONE_P   = {1'b1, {(FB + 1){1'b0}}};
  localparam logic [FB-1:0]     HALF    = {1'b1, {(FB - 1){1'b0}}};
  localparam logic [63:0]       RND_Q32 = 64'h0000_0000_8000_0000;

  // Pileup symbols.
  localparam logic [7:0] SYM_REF_UC = 8'h52;   // 'R'
  localparam logic [7:0] SYM_REF_LC = 8'h72;   // 'r'
  localparam logic [7:0] SYM_CASE   = 8'd32;   // lower case offset

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TUMOR_FRACTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_GENOTYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT_LETTER = 2'd2;

  // Joint genotype codes, normal/tumor.
  localparam logic [3:0] GT_AA_AA = 4'd0;
  localparam logic [3:0] GT_AA_AB = 4'd1;
  localparam logic [3:0] GT_AA_BB = 4'd2;
  localparam logic [3:0] GT_AB_AA = 4'd3;
  localparam logic [3:0] GT_AB_AB = 4'd4;
  localparam logic [3:0] GT_AB_BB = 4'd5;
  localparam logic [3:0] GT_BB_AA = 4'd6;
  localparam logic [3:0] GT_BB_AB = 4'd7;
  localparam logic [3:0] GT_BB_BB = 4'd8;

  // Variant letter codes.
  localparam logic [1:0] VL_A = 2'd0;
  localparam logic [1:0] VL_C = 2'd1;
  localparam logic [1:0] VL_G = 2'd2;
  localparam logic [1:0] VL_T = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_PA,
    ST_MUL_PB,
    ST_SUM_T,
    ST_NORM,
    ST_SQR_MUL,
    ST_SQR_UPD,
    ST_LN_MAG,
    ST_LN_MUL,
    ST_ACC,
    ST_FIN
  } grll_state_t;

  // Probabilities above one saturate to one.
  function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
    sat_prob = (v > ONE_F) ? ONE_F : v;
  endfunction

  function automatic logic [7:0] variant_ascii(input logic [1:0] code);
    logic [7:0] c;
    c = 8'h41;
    case (code)
      VL_A: c = 8'h41;
      VL_C: c = 8'h43;
      VL_G: c = 8'h47;
      VL_T: c = 8'h54;
      default: c = 8'h41;
    endcase
    variant_ascii = c;
  endfunction

endpackage

// ===== design/genotype_read_log_likelihood.sv =====
// A counted read occupies the block from its transfer through the shared
// multiplier states, normalisation and the 16 squaring iterations of the log2
// sequence to the accumulation; in_ready stays low until the block is idle.
// A read marked last then loads the result register in ST_FIN, which waits
// while the output is stalled. An uncounted read skips the sequence.
// Reset (rst_n low, synchronous) clears state, config, sum, count and out_valid.
`timescale 1ns / 1ps

module genotype_read_log_likelihood (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_base_symbol,
  input  logic [grll_pkg::PROB_W-1:0]         in_base_error,
  input  logic [grll_pkg::PROB_W-1:0]         in_map_error,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [grll_pkg::SUM_W-1:0]   out_log_likelihood,
  output logic [grll_pkg::CNT_W-1:0]          out_reads_used,
  input  logic                                cfg_we,
  input  logic [grll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grll_pkg::CFG_W-1:0]          cfg_data
);

  localparam int FB     = grll_pkg::FB;
  localparam int PROB_W = grll_pkg::PROB_W;
  localparam int P_W    = grll_pkg::P_W;
  localparam int B_W    = grll_pkg::B_W;
  localparam int T_W    = grll_pkg::T_W;
  localparam int E_W    = grll_pkg::E_W;
  localparam int NSTEPS = grll_pkg::NSTEPS;
  localparam int STEP_W = grll_pkg::STEP_W;
  localparam int ITER_W = grll_pkg::ITER_W;
  localparam int IP_W   = grll_pkg::IP_W;
  localparam int L_W    = grll_pkg::L_W;
  localparam int Y_W    = grll_pkg::Y_W;
  localparam int MUL_W  = grll_pkg::MUL_W;
  localparam int SUM_W  = grll_pkg::SUM_W;
  localparam int CNT_W  = grll_pkg::CNT_W;

  // Configuration registers.
  logic [PROB_W-1:0] tf_r;
  logic [3:0]        gt_r;
  logic [1:0]        vl_r;

  grll_pkg::grll_state_t state_r, state_nxt;

  // Datapath registers.
  logic [PROB_W-1:0]      q_r, m_r, a_r;
  logic [P_W-1:0]         p_r;
  logic [B_W-1:0]         b_r;
  logic                   last_r;
  logic [2*MUL_W-1:0]     prod_r;
  logic [T_W-1:0]         t_r, x_r;
  logic [E_W-1:0]         e_r;
  logic [STEP_W-1:0]      step_r;
  logic [ITER_W-1:0]      iter_r;
  logic [Y_W-1:0]         y_r;
  logic [FB-1:0]          frac_r;
  logic [L_W-1:0]         mag_r;
  logic                   neg_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]       count_r;
  logic                   out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [CNT_W-1:0]       out_count_r;

  // Read classification and the genotype rule.
  logic                   accept;
  logic                   sym_ref, sym_var, used;
  logic [7:0]             vu;
  logic [PROB_W-1:0]      f_sat;
  logic [P_W-1:0]         pr, p_in;
  logic                   gt_ok;

  // Shared multiplier.
  logic [MUL_W-1:0]       mul_x, mul_y;

  // Datapath helpers.
  logic [2*FB:0]          rnd_prod;
  logic [T_W-1:0]         t_sum;
  logic [E_W-1:0]         shamt;
  logic                   hi_zero;
  logic [T_W-1:0]         x_sh;
  logic [T_W+Y_W-1:0]     x_ext;
  logic [Y_W:0]           sq;
  logic signed [IP_W-1:0] ip_val;
  logic signed [L_W-1:0]  l_val;
  logic [63:0]            rnd_ln;
  logic [L_W-1:0]         r_val;
  logic signed [L_W:0]    term;
  logic signed [SUM_W:0]  acc;
  logic signed [SUM_W-1:0] acc_sat;
  logic                   fin_load;

  assign in_ready           = (state_r == grll_pkg::ST_IDLE);
  assign accept             = in_valid && in_ready;
  assign out_valid          = out_valid_r;
  assign out_log_likelihood = out_sum_r;
  assign out_reads_used     = out_count_r;
  assign fin_load           = !out_valid_r || out_ready;

  always_comb begin
    vu      = grll_pkg::variant_ascii(vl_r);
    sym_ref = (in_base_symbol == grll_pkg::SYM_REF_UC) ||
              (in_base_symbol == grll_pkg::SYM_REF_LC);
    sym_var = !sym_ref && ((in_base_symbol == vu) ||
              (in_base_symbol == (vu + grll_pkg::SYM_CASE)));
    used    = sym_ref || sym_var;
    f_sat   = grll_pkg::sat_prob(tf_r);
    gt_ok   = 1'b1;
    pr      = '0;
    unique case (gt_r)
      grll_pkg::GT_AA_AA: pr = grll_pkg::ONE_P;
      grll_pkg::GT_AA_AB: pr = grll_pkg::ONE_P - P_W'(f_sat);
      grll_pkg::GT_AA_BB: pr = grll_pkg::ONE_P - {f_sat, 1'b0};
      grll_pkg::GT_AB_AA: pr = P_W'(grll_pkg::ONE_F) + P_W'(f_sat);
      grll_pkg::GT_AB_AB: pr = P_W'(grll_pkg::ONE_F);
      grll_pkg::GT_AB_BB: pr = P_W'(grll_pkg::ONE_F) - P_W'(f_sat);
      grll_pkg::GT_BB_AA: pr = {f_sat, 1'b0};
      grll_pkg::GT_BB_AB: pr = P_W'(f_sat);
      grll_pkg::GT_BB_BB: pr = '0;
      default: begin
        pr    = '0;
        gt_ok = 1'b0;
      end
    endcase
    // An unknown genotype gives a zero chance to either class.
    p_in = sym_ref ? pr : (gt_ok ? (grll_pkg::ONE_P - pr) : '0);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      grll_pkg::ST_MUL_A: begin
        mul_x = MUL_W'(grll_pkg::ONE_F - q_r);
        mul_y = MUL_W'(grll_pkg::ONE_F - m_r);
      end
      grll_pkg::ST_MUL_B: begin
        mul_x = MUL_W'(q_r);
        mul_y = MUL_W'(m_r);
      end
      grll_pkg::ST_MUL_PA: begin
        mul_x = MUL_W'(p_r);
        mul_y = MUL_W'(a_r);
      end
      grll_pkg::ST_MUL_PB: begin
        mul_x = MUL_W'(grll_pkg::ONE_P - p_r);
        mul_y = MUL_W'(b_r);
      end
      grll_pkg::ST_SQR_MUL: begin
        mul_x = MUL_W'(y_r);
        mul_y = MUL_W'(y_r);
      end
      grll_pkg::ST_LN_MUL: begin
        mul_x = MUL_W'(mag_r);
        mul_y = grll_pkg::LN2_Q32;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_comb begin
    rnd_prod = prod_r[2*FB:0] + (2*FB+1)'(grll_pkg::HALF);
    t_sum    = t_r + prod_r[T_W-1:0];
    shamt    = E_W'(1) << (STEP_W'(NSTEPS - 1) - step_r);
    hi_zero  = ((x_r >> (E_W'(T_W) - shamt)) == '0);
    x_sh     = hi_zero ? (x_r << shamt) : x_r;
    x_ext    = {x_sh, {Y_W{1'b0}}};
    sq       = prod_r[2*(Y_W-1)+1:Y_W-1];
    ip_val   = $signed({1'b0, e_r}) - IP_W'(2 * FB + 1);
    l_val    = $signed({ip_val, frac_r});
    rnd_ln   = prod_r + grll_pkg::RND_Q32;
    r_val    = rnd_ln[L_W+31:32];
    term     = neg_r ? -$signed({1'b0, r_val}) : $signed({1'b0, r_val});
    acc      = $signed({sum_r[SUM_W-1], sum_r}) + (SUM_W+1)'(term);
    // Overflow shows as a disagreement of the two top bits.
    if (acc[SUM_W] != acc[SUM_W-1]) begin
      acc_sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc[SUM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grll_pkg::ST_IDLE: begin
        if (accept) begin
          if (used) begin
            state_nxt = grll_pkg::ST_MUL_A;
          end else if (in_last) begin
            state_nxt = grll_pkg::ST_FIN;
          end
        end
      end
      grll_pkg::ST_MUL_A:  state_nxt = grll_pkg::ST_MUL_B;
      grll_pkg::ST_MUL_B:  state_nxt = grll_pkg::ST_MUL_PA;
      grll_pkg::ST_MUL_PA: state_nxt = grll_pkg::ST_MUL_PB;
      grll_pkg::ST_MUL_PB: state_nxt = grll_pkg::ST_SUM_T;
      grll_pkg::ST_SUM_T:  state_nxt = grll_pkg::ST_NORM;
      grll_pkg::ST_NORM: begin
        if (step_r == STEP_W'(NSTEPS - 1)) begin
          state_nxt = grll_pkg::ST_SQR_MUL;
        end
      end
      grll_pkg::ST_SQR_MUL: state_nxt = grll_pkg::ST_SQR_UPD;
      grll_pkg::ST_SQR_UPD: begin
        state_nxt = (iter_r == ITER_W'(FB - 1)) ? grll_pkg::ST_LN_MAG
                                                 : grll_pkg::ST_SQR_MUL;
      end
      grll_pkg::ST_LN_MAG: state_nxt = grll_pkg::ST_LN_MUL;
      grll_pkg::ST_LN_MUL: state_nxt = grll_pkg::ST_ACC;
      grll_pkg::ST_ACC: begin
        state_nxt = last_r ? grll_pkg::ST_FIN : grll_pkg::ST_IDLE;
      end
      grll_pkg::ST_FIN: begin
        if (fin_load) begin
          state_nxt = grll_pkg::ST_IDLE;
        end
      end
      default: state_nxt = grll_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grll_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, accumulator and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tf_r        <= '0;
      gt_r        <= '0;
      vl_r        <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          grll_pkg::CFG_TUMOR_FRACTION: tf_r <= cfg_data[PROB_W-1:0];
          grll_pkg::CFG_JOINT_GENOTYPE: gt_r <= cfg_data[3:0];
          grll_pkg::CFG_VARIANT_LETTER: vl_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state_r == grll_pkg::ST_ACC) begin
        sum_r <= acc_sat;
        if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (state_r == grll_pkg::ST_FIN && fin_load) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        count_r     <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_x * mul_y;
    if (state_r == grll_pkg::ST_FIN && fin_load) begin
      out_sum_r   <= sum_r;
      out_count_r <= count_r;
    end
    unique case (state_r)
      grll_pkg::ST_IDLE: begin
        if (accept) begin
          q_r    <= grll_pkg::sat_prob(in_base_error);
          m_r    <= grll_pkg::sat_prob(in_map_error);
          p_r    <= p_in;
          last_r <= in_last;
        end
      end
      grll_pkg::ST_MUL_B: a_r <= rnd_prod[2*FB:FB];
      grll_pkg::ST_MUL_PA: begin
        b_r <= B_W'(q_r) + B_W'(m_r) + B_W'(rnd_prod[2*FB:FB]);
      end
      grll_pkg::ST_MUL_PB: t_r <= prod_r[T_W-1:0];
      grll_pkg::ST_SUM_T: begin
        // A zero mixture is taken as one LSB so that the log stays finite.
        x_r    <= (t_sum == '0) ? T_W'(1) : t_sum;
        e_r    <= E_W'(T_W - 1);
        step_r <= '0;
      end
      grll_pkg::ST_NORM: begin
        x_r    <= x_sh;
        y_r    <= x_ext[T_W+Y_W-1 -: Y_W];
        step_r <= step_r + 1'b1;
        if (hi_zero) begin
          e_r <= e_r - shamt;
        end
        iter_r <= '0;
        frac_r <= '0;
      end
      grll_pkg::ST_SQR_UPD: begin
        if (sq[Y_W]) begin
          y_r    <= sq[Y_W:1];
          frac_r <= {frac_r[FB-2:0], 1'b1};
        end else begin
          y_r    <= sq[Y_W-1:0];
          frac_r <= {frac_r[FB-2:0], 1'b0};
        end
        iter_r <= iter_r + 1'b1;
      end
      grll_pkg::ST_LN_MAG: begin
        neg_r <= l_val[L_W-1];
        mag_r <= l_val[L_W-1] ? L_W'(-l_val) : L_W'(l_val);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && used |=> !in_ready)
    else $error("block took a further read while a counted read was at work");

  a_norm_leading_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == grll_pkg::ST_NORM && step_r == STEP_W'(NSTEPS - 1) |=> x_r[T_W-1])
    else $error("normalisation ended without a leading one in the top bit");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == grll_pkg::ST_FIN && fin_load |=> out_valid && sum_r == '0 && count_r == '0)
    else $error("result load did not raise valid and clear the accumulator");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r != grll_pkg::ST_FIN |=> count_r >= $past(count_r))
    else $error("read counter fell outside a result load");
`endif

endmodule

// ===== bench/tb_genotype_read_log_likelihood.sv =====
// Self-checking bench for the genotype read log-likelihood accumulator.
// Drives pileup reads under a series of register settings and compares each site total
// with a fixed-point predictor of its own. Depends on grll_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_genotype_read_log_likelihood;

  localparam int FB        = grll_pkg::FB;
  localparam int PROB_W    = grll_pkg::PROB_W;
  localparam int SUM_W     = grll_pkg::SUM_W;
  localparam int CNT_W     = grll_pkg::CNT_W;
  localparam int CFG_IDX_W = grll_pkg::CFG_IDX_W;
  localparam int CFG_W     = grll_pkg::CFG_W;

  typedef struct packed {
    logic [7:0]        sym;
    logic [PROB_W-1:0] q;
    logic [PROB_W-1:0] m;
    logic              last;
  } read_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] ll;
    logic [CNT_W-1:0]        cnt;
  } site_total_t;

  typedef enum logic [1:0] {CLS_IGNORED, CLS_REF, CLS_VAR} read_class_t;

  localparam longint unsigned UNIT     = 64'd1 << FB;
  localparam longint unsigned P_UNIT   = 64'd2 << FB;
  localparam longint unsigned HALF_LSB = 64'd1 << (FB - 1);
  localparam longint SUM_TOP    = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_BOTTOM = -(longint'(1) << (SUM_W - 1));
  localparam int unsigned COUNT_TOP = (1 << CNT_W) - 1;
  localparam logic [7:0] SYM_IGNORED_X = 8'h58;
  localparam int IDLE_PCT     = 36;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int READS_PER_SETTING = 80;
  localparam int SETTINGS_RUN = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_base_symbol = '0;
  logic [PROB_W-1:0] in_base_error = '0;
  logic [PROB_W-1:0] in_map_error = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_log_likelihood;
  logic [CNT_W-1:0] out_reads_used;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  genotype_read_log_likelihood dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_base_symbol(in_base_symbol), .in_base_error(in_base_error),
    .in_map_error(in_map_error), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_log_likelihood(out_log_likelihood), .out_reads_used(out_reads_used),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and its copy of the registers.
  logic [PROB_W-1:0] cfg_frac = '0;
  logic [3:0]        cfg_gt = '0;
  logic [1:0]        cfg_var = '0;
  longint            acc_sum = 0;
  int unsigned       acc_count = 0;

  read_t       read_q[$];
  site_total_t site_totals_q[$];
  read_t       cur_read;
  int          reads_queued = 0;
  int          reads_accepted = 0;
  int          reads_summed = 0;
  int          sites_closed = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  bit          pressure = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] letter_of(input logic [1:0] code);
    logic [7:0] c;
    case (code)
      grll_pkg::VL_A: c = 8'h41;
      grll_pkg::VL_C: c = 8'h43;
      grll_pkg::VL_G: c = 8'h47;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic read_class_t classify(input logic [7:0] sym);
    logic [7:0] v;
    v = letter_of(cfg_var);
    if (sym == grll_pkg::SYM_REF_UC || sym == grll_pkg::SYM_REF_LC) return CLS_REF;
    if (sym == v || sym == v + grll_pkg::SYM_CASE) return CLS_VAR;
    return CLS_IGNORED;
  endfunction

  function automatic longint unsigned clamp_unit(input logic [PROB_W-1:0] v);
    return (longint'(v) > UNIT) ? UNIT : longint'(v);
  endfunction

  // Natural log of a mixture with 2FB+1 fraction bits, giving FB fraction bits.
  function automatic longint ln_fixed(input longint unsigned t);
    longint unsigned tt, y, frac, mag, r;
    longint l;
    int k, i;
    tt = (t == 0) ? 64'd1 : t;
    k = 0;
    for (i = 0; i < 64; i++) begin
      if (tt[i]) k = i;
    end
    if (k >= 30) y = tt >> (k - 30);
    else y = tt << (30 - k);
    frac = 0;
    for (i = 0; i < FB; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    l = longint'(k - (2 * FB + 1)) * longint'(UNIT) + longint'(frac);
    mag = (l < 0) ? longint'(-l) : longint'(l);
    r = (mag * longint'(grll_pkg::LN2_Q32) + 64'h8000_0000) >> 32;
    return (l < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void accumulate_read(input read_t rd);
    read_class_t cls;
    longint unsigned q, m, f, pr, p, a, b, t;
    longint s;
    logic known;
    site_total_t tot;
    cls = classify(rd.sym);
    q = clamp_unit(rd.q);
    m = clamp_unit(rd.m);
    if (cls != CLS_IGNORED) begin
      f = clamp_unit(cfg_frac);
      known = 1'b1;
      case (cfg_gt)
        grll_pkg::GT_AA_AA: pr = P_UNIT;
        grll_pkg::GT_AA_AB: pr = P_UNIT - f;
        grll_pkg::GT_AA_BB: pr = P_UNIT - 2 * f;
        grll_pkg::GT_AB_AA: pr = UNIT + f;
        grll_pkg::GT_AB_AB: pr = UNIT;
        grll_pkg::GT_AB_BB: pr = UNIT - f;
        grll_pkg::GT_BB_AA: pr = 2 * f;
        grll_pkg::GT_BB_AB: pr = f;
        grll_pkg::GT_BB_BB: pr = 0;
        default: begin
          pr = 0;
          known = 1'b0;
        end
      endcase
      // An unknown genotype gives no chance to either class.
      if (cls == CLS_REF) p = pr;
      else p = known ? P_UNIT - pr : 0;
      a = ((UNIT - q) * (UNIT - m) + HALF_LSB) >> FB;
      b = q + m + ((q * m + HALF_LSB) >> FB);
      t = p * a + (P_UNIT - p) * b;
      s = acc_sum + ln_fixed(t);
      if (s > SUM_TOP) s = SUM_TOP;
      if (s < SUM_BOTTOM) s = SUM_BOTTOM;
      acc_sum = s;
      if (acc_count < COUNT_TOP) acc_count++;
      reads_summed++;
    end
    if (rd.last) begin
      tot.ll = acc_sum[SUM_W-1:0];
      tot.cnt = acc_count[CNT_W-1:0];
      site_totals_q = {site_totals_q, tot};
      acc_sum = 0;
      acc_count = 0;
      sites_closed++;
    end
  endfunction

  function automatic logic [PROB_W-1:0] rand_prob();
    int r;
    r = $urandom_range(99);
    if (r < 40) return PROB_W'($urandom_range(32'(UNIT)));
    if (r < 55) return PROB_W'($urandom_range(2000));
    if (r < 65) return PROB_W'(UNIT - 64'($urandom_range(2000)));
    if (r < 72) return '0;
    if (r < 79) return PROB_W'(UNIT);
    return PROB_W'($urandom_range((1 << PROB_W) - 1));
  endfunction

  function automatic read_t rand_read(input logic last);
    read_t rd;
    int r;
    r = $urandom_range(99);
    if (r < 18) rd.sym = grll_pkg::SYM_REF_UC;
    else if (r < 36) rd.sym = grll_pkg::SYM_REF_LC;
    else if (r < 54) rd.sym = letter_of(cfg_var);
    else if (r < 72) rd.sym = letter_of(cfg_var) + grll_pkg::SYM_CASE;
    else if (r < 82) rd.sym = SYM_IGNORED_X;
    else rd.sym = 8'($urandom_range(255));
    rd.q = rand_prob();
    rd.m = rand_prob();
    rd.last = last;
    return rd;
  endfunction

  task automatic queue_read(input logic [7:0] sym, input longint unsigned q,
                            input longint unsigned m, input logic last);
    read_t rd;
    rd.sym = sym;
    rd.q = q[PROB_W-1:0];
    rd.m = m[PROB_W-1:0];
    rd.last = last;
    read_q = {read_q, rd};
    reads_queued++;
  endtask

  // Waits until every queued read is taken and every site total has come back,
  // then lets the block finish any read that yields no result.
  task automatic wait_idle();
    do @(posedge clk);
    while (!(reads_accepted == reads_queued && site_totals_q.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      grll_pkg::CFG_TUMOR_FRACTION: cfg_frac = value[PROB_W-1:0];
      grll_pkg::CFG_JOINT_GENOTYPE: cfg_gt = value[3:0];
      default: cfg_var = value[1:0];
    endcase
  endtask

  // Driver: offers the next pending read; valid holds until the transfer.
  always @(posedge clk) begin : read_driver
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accumulate_read(cur_read);
        reads_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && read_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur_read = read_q.pop_front();
        in_base_symbol <= cur_read.sym;
        in_base_error <= cur_read.q;
        in_map_error <= cur_read.m;
        in_last <= cur_read.last;
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  // Monitor: checks each site total against the oldest prediction.
  always @(posedge clk) begin : total_monitor
    site_total_t want;
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (site_totals_q.size() == 0) begin
          $display("%0t: unexpected result, log_likelihood %0d reads_used %0d",
                   $time, out_log_likelihood, out_reads_used);
          errors++;
        end else begin
          want = site_totals_q.pop_front();
          if (out_log_likelihood !== want.ll) begin
            $display("%0t: log_likelihood expected %0d, actual %0d",
                     $time, want.ll, out_log_likelihood);
            errors++;
          end
          if (out_reads_used !== want.cnt) begin
            $display("%0t: reads_used expected %0d, actual %0d",
                     $time, want.cnt, out_reads_used);
            errors++;
          end
        end
      end
      if (pressure && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      else nxt_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph, summed, len, i;
    longint unsigned frac;
    read_t rd;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed reads under the reset settings: reference genotype, variant A.
    queue_read(grll_pkg::SYM_REF_UC, 0, 0, 1'b0);       // certain reference read
    queue_read(grll_pkg::SYM_REF_LC, UNIT, 0, 1'b0);    // mixture of zero
    queue_read(letter_of(grll_pkg::VL_A), 0, 0, 1'b0);  // zero again, variant side
    queue_read(letter_of(grll_pkg::VL_A) + grll_pkg::SYM_CASE, UNIT, UNIT, 1'b0);
    queue_read(SYM_IGNORED_X, 0, 0, 1'b0);
    queue_read(grll_pkg::SYM_REF_UC, (1 << PROB_W) - 1, (1 << PROB_W) - 1, 1'b0);
    queue_read(letter_of(grll_pkg::VL_G), 100, 100, 1'b0);
    queue_read(8'h00, UNIT, 0, 1'b0);
    queue_read(8'hFF, 0, UNIT, 1'b0);
    queue_read(grll_pkg::SYM_REF_UC, 1, UNIT - 1, 1'b1);
    queue_read(SYM_IGNORED_X, 5, 5, 1'b1);              // ignored read still closes a site
    queue_read(SYM_IGNORED_X, UNIT + 1, 0, 1'b1);       // site with nothing summed
    queue_read(grll_pkg::SYM_REF_LC, UNIT - 1, 1, 1'b1);
    queue_read(letter_of(grll_pkg::VL_A) + grll_pkg::SYM_CASE, UNIT / 2, UNIT / 2, 1'b1);
    queue_read(letter_of(grll_pkg::VL_A), UNIT + 7, 1, 1'b0);
    queue_read(grll_pkg::SYM_REF_UC, 12345, 54321, 1'b1);

    for (ph = 0; ph < SETTINGS_RUN; ph++) begin
      wait_idle();
      case (ph % 8)
        0: frac = 0;
        1: frac = UNIT;
        2: frac = (1 << PROB_W) - 1;
        3: frac = UNIT / 2;
        4: frac = 1;
        5: frac = UNIT - 1;
        6: frac = 64'($urandom_range(32'(UNIT)));
        default: frac = 64'($urandom_range((1 << PROB_W) - 1));
      endcase
      write_reg(grll_pkg::CFG_TUMOR_FRACTION, frac);
      write_reg(grll_pkg::CFG_JOINT_GENOTYPE, 64'(ph));
      write_reg(grll_pkg::CFG_VARIANT_LETTER, 64'((ph + ph / 4) % 4));
      calm = (ph == 5);
      pressure = (ph == 9);
      summed = 0;
      while (summed < READS_PER_SETTING) begin
        len = pressure ? int'($urandom_range(3, 1)) : int'($urandom_range(10, 1));
        for (i = 0; i < len; i++) begin
          rd = rand_read(i == len - 1);
          if (classify(rd.sym) != CLS_IGNORED) summed++;
          queue_read(rd.sym, rd.q, rd.m, rd.last);
        end
      end
    end
    wait_idle();
    calm = 1'b0;
    pressure = 1'b0;

    $display("Ran %0d reads (%0d summed) closing %0d sites over %0d register settings,",
             reads_accepted, reads_summed, sites_closed, SETTINGS_RUN + 1);
    $display("covering every genotype code, every variant letter and saturated inputs.");
    if (errors == 0 && site_totals_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/grll_pkg.sv
design/genotype_read_log_likelihood.sv
bench/tb_genotype_read_log_likelihood.sv
